// File: rtl/core/cdd_pkg.sv
`default_nettype none

package cdd_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int CountW = 22;
	localparam int SumW   = 23;
	localparam int DiffW  = 24;
	localparam int DoyW   = 9;

	localparam int MaxYearDefault = 9999;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	localparam logic [MonthW-1:0] MonJan = 4'd1;
	localparam logic [MonthW-1:0] MonFeb = 4'd2;
	localparam logic [MonthW-1:0] MonDec = 4'd12;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic fin1;
		logic fin2;
	} cdd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
	} cdd_sts_t;

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
		logic [DayW-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
		logic [DoyW-1:0] n;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/cdd_ctrl.sv
`default_nettype none

module cdd_ctrl
	import cdd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	output cdd_cmd_t      cmd,
	input  wire cdd_sts_t sts
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StSweep = 2'd1;
	localparam logic [1:0] StFin1  = 2'd2;
	localparam logic [1:0] StFin2  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != StIdle);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = StSweep;
				end
			end
			StSweep: begin
				cmd.step = 1'b1;
				if (sts.sweep_last) state_d = StFin1;
			end
			StFin1: begin
				cmd.fin1 = 1'b1;
				state_d  = StFin2;
			end
			StFin2: begin
				// result waits here until the output register frees up
				if (out_free) begin
					cmd.fin2 = 1'b1;
					state_d  = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin2) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cdd_dpath.sv
`default_nettype none

module cdd_dpath
	import cdd_pkg::*;
#(
	parameter int MAX_YEAR = MaxYearDefault
) (
	input  wire logic              clk,
	input  wire cdd_cmd_t          cmd,
	output cdd_sts_t               sts,
	input  wire logic [DayW-1:0]   first_day,
	input  wire logic [MonthW-1:0] first_month,
	input  wire logic [YearW-1:0]  first_year,
	input  wire logic [DayW-1:0]   second_day,
	input  wire logic [MonthW-1:0] second_month,
	input  wire logic [YearW-1:0]  second_year,
	input  wire logic              include_end_day,
	output logic [CountW-1:0]      day_count,
	output logic                   date_invalid
);

	localparam logic [YearW:0] MaxYearW = (YearW+1)'(MAX_YEAR);

	logic [DayW-1:0]   d1_q, d2_q;
	logic [MonthW-1:0] m1_q, m2_q;
	logic [YearW-1:0]  y1_q, y2_q, ymin_q, ymax_q, yr_q;
	logic              inc_q, leap1_q, leap2_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [SumW-1:0]   sum_q;
	logic [DiffW-1:0]  diff_s1;
	logic              inv_s1;
	logic [CountW-1:0] count_q;
	logic              invalid_q;

	logic              leap_yr;
	logic [DayW-1:0]   len1, len2;
	logic              ok1, ok2;
	logic [DoyW-1:0]   doy1, doy2;
	logic [DiffW-1:0]  diff_d, mag;
	logic [DiffW:0]    total;

	assign sts.sweep_last = (yr_q == ymax_q);

	// gregorian leap rule from running residues of the swept year
	assign leap_yr = (yr_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));

	always_comb begin
		len1 = (m1_q == MonFeb) ? (leap1_q ? 5'd29 : 5'd28) : month_len(m1_q);
		len2 = (m2_q == MonFeb) ? (leap2_q ? 5'd29 : 5'd28) : month_len(m2_q);
		ok1  = (m1_q >= MonJan) && (m1_q <= MonDec) && ({1'b0, y1_q} <= MaxYearW)
			&& (d1_q != '0) && (d1_q <= len1);
		ok2  = (m2_q >= MonJan) && (m2_q <= MonDec) && ({1'b0, y2_q} <= MaxYearW)
			&& (d2_q != '0) && (d2_q <= len2);
		doy1 = days_before(m1_q) + DoyW'(d1_q) + DoyW'((m1_q > MonFeb) && leap1_q);
		doy2 = days_before(m2_q) + DoyW'(d2_q) + DoyW'((m2_q > MonFeb) && leap2_q);
		if (y1_q > y2_q) begin
			diff_d = DiffW'(sum_q) + DiffW'(doy1) - DiffW'(doy2);
		end else begin
			diff_d = DiffW'(sum_q) + DiffW'(doy2) - DiffW'(doy1);
		end
		mag   = diff_s1[DiffW-1] ? (~diff_s1 + 1'b1) : diff_s1;
		total = {1'b0, mag} + (DiffW+1)'(inc_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d1_q   <= first_day;
			m1_q   <= first_month;
			y1_q   <= first_year;
			d2_q   <= second_day;
			m2_q   <= second_month;
			y2_q   <= second_year;
			inc_q  <= include_end_day;
			ymin_q <= (first_year < second_year) ? first_year : second_year;
			ymax_q <= (first_year < second_year) ? second_year : first_year;
			yr_q   <= '0;
			c100_q <= '0;
			c400_q <= '0;
			sum_q  <= '0;
		end
		if (cmd.step) begin
			yr_q   <= yr_q + 1'b1;
			c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 1'b1;
			c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 1'b1;
			if (yr_q == y1_q) leap1_q <= leap_yr;
			if (yr_q == y2_q) leap2_q <= leap_yr;
			if ((yr_q >= ymin_q) && (yr_q != ymax_q)) begin
				sum_q <= sum_q + (leap_yr ? SumW'(366) : SumW'(365));
			end
		end
		if (cmd.fin1) begin
			diff_s1 <= diff_d;
			inv_s1  <= !(ok1 && ok2);
		end
		if (cmd.fin2) begin
			invalid_q <= inv_s1;
			if (inv_s1) count_q <= '0;
			else if (total > (DiffW+1)'(CountMax)) count_q <= CountMax;
			else count_q <= total[CountW-1:0];
		end
	end

	assign day_count    = count_q;
	assign date_invalid = invalid_q;

endmodule

`default_nettype wire

// File: rtl/core/calendar_day_difference.sv
// calendar_day_difference: days between two gregorian dates
//
// input channel: in_valid/in_stall with both dates and include_end_day;
//   a transaction is taken when in_valid is high and in_stall is low
// output channel: out_valid/out_stall with day_count and date_invalid;
//   one result transaction for every input transaction, in order
// the year sweep visits every year from 0 up to the later year, one year
//   per cycle, and sets the rate
// throughput: one transaction at a time; in_stall is high from acceptance
//   until the result is written into the output register
// a finished result sits in the output register; the next input transaction
//   is accepted while it waits, and its own result is held back until the
//   register is taken
// out of range dates (bad month, day zero or past month end, year past
//   MAX_YEAR) give date_invalid = 1 and day_count = 0
// reset (arst_n low) empties the block: no result pending, ready for input
`default_nettype none

module calendar_day_difference
	import cdd_pkg::*;
#(
	parameter int MAX_YEAR = MaxYearDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [DayW-1:0]   first_day,
	input  wire logic [MonthW-1:0] first_month,
	input  wire logic [YearW-1:0]  first_year,
	input  wire logic [DayW-1:0]   second_day,
	input  wire logic [MonthW-1:0] second_month,
	input  wire logic [YearW-1:0]  second_year,
	input  wire logic              include_end_day,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CountW-1:0]      day_count,
	output logic                   date_invalid
);

	cdd_cmd_t cmd;
	cdd_sts_t sts;

	// sequencer: idle, year sweep, check and subtract, absolute value and output
	cdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// year accumulator, leap tracking, range checks and result register
	cdd_dpath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.sts             (sts),
		.first_day       (first_day),
		.first_month     (first_month),
		.first_year      (first_year),
		.second_day      (second_day),
		.second_month    (second_month),
		.second_year     (second_year),
		.include_end_day (include_end_day),
		.day_count       (day_count),
		.date_invalid    (date_invalid)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_calendar_day_difference.sv
`default_nettype none

module tb_calendar_day_difference;
	import cdd_pkg::*;

	// slowest item: a year sweep up to 2**14 - 1;
	// 121 transactions of that size plus random gaps and stalls, taken about 3x over
	localparam int unsigned RunLimitCycles = 7_000_000;
	// after the last result, wait out one full sweep to catch a stray result
	localparam int unsigned DrainCycles    = (1 << YearW) + 8;
	localparam int unsigned RandomQueries  = 100;
	localparam int unsigned PhaseLength    = 25;

	// one input transaction: two dates and the end-day bit
	typedef struct {
		logic [DayW-1:0]   first_day;
		logic [MonthW-1:0] first_month;
		logic [YearW-1:0]  first_year;
		logic [DayW-1:0]   second_day;
		logic [MonthW-1:0] second_month;
		logic [YearW-1:0]  second_year;
		logic              include_end_day;
	} date_query_t;

	// one output transaction
	typedef struct {
		logic [CountW-1:0] day_count;
		logic              date_invalid;
	} day_gap_t;

	// predicts the day gap of each accepted query and checks results in order
	class day_gap_scoreboard;
		day_gap_t    expected_gaps[$];
		int unsigned mismatches = 0;
		int unsigned month_days[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		function bit leap_year(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		// month must already be in range
		function int unsigned days_in(int unsigned m, int unsigned y);
			if (m == MonFeb && leap_year(y))
				return 29;
			return month_days[m];
		endfunction

		function bit real_date(int unsigned d, int unsigned m, int unsigned y);
			if (m < MonJan || m > MonDec || y > MaxYearDefault)
				return 1'b0;
			return (d >= 1) && (d <= days_in(m, y));
		endfunction

		// days since a fixed origin, year zero counted as a leap year
		function int unsigned serial_day(int unsigned d, int unsigned m, int unsigned y);
			int unsigned n;
			n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
			for (int unsigned k = MonJan; k < m; k++)
				n += days_in(k, y);
			return n + d;
		endfunction

		function void note_query(date_query_t q);
			day_gap_t    gap;
			int unsigned a;
			int unsigned b;
			int unsigned span;
			if (!real_date(q.first_day, q.first_month, q.first_year) ||
			    !real_date(q.second_day, q.second_month, q.second_year)) begin
				gap.day_count    = '0;
				gap.date_invalid = 1'b1;
			end else begin
				a    = serial_day(q.first_day, q.first_month, q.first_year);
				b    = serial_day(q.second_day, q.second_month, q.second_year);
				span = (a > b) ? a - b : b - a;
				span += q.include_end_day;
				gap.day_count    = (span > CountMax) ? CountMax : span[CountW-1:0];
				gap.date_invalid = 1'b0;
			end
			expected_gaps.push_back(gap);
		endfunction

		function void check_result(logic [CountW-1:0] day_count, logic date_invalid);
			day_gap_t gap;
			if (expected_gaps.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got day_count %0d date_invalid %0b",
					$time, day_count, date_invalid);
				return;
			end
			gap = expected_gaps.pop_front();
			if (day_count !== gap.day_count) begin
				mismatches++;
				$display("%0t: day_count expected %0d, got %0d", $time, gap.day_count, day_count);
			end
			if (date_invalid !== gap.date_invalid) begin
				mismatches++;
				$display("%0t: date_invalid expected %0b, got %0b",
					$time, gap.date_invalid, date_invalid);
			end
		endfunction

		function int unsigned outstanding();
			return expected_gaps.size();
		endfunction
	endclass

	// clock, reset and every block input start at known values
	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              in_valid        = 1'b0;
	logic              in_stall;
	logic [DayW-1:0]   first_day       = '0;
	logic [MonthW-1:0] first_month     = '0;
	logic [YearW-1:0]  first_year      = '0;
	logic [DayW-1:0]   second_day      = '0;
	logic [MonthW-1:0] second_month    = '0;
	logic [YearW-1:0]  second_year     = '0;
	logic              include_end_day = 1'b0;
	logic              out_valid;
	logic              out_stall       = 1'b0;
	logic [CountW-1:0] day_count;
	logic              date_invalid;

	// idle and stall odds in percent, changed per phase
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count    = 0;

	day_gap_scoreboard scoreboard = new();

	calendar_day_difference dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.first_day       (first_day),
		.first_month     (first_month),
		.first_year      (first_year),
		.second_day      (second_day),
		.second_month    (second_month),
		.second_year     (second_year),
		.include_end_day (include_end_day),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.day_count       (day_count),
		.date_invalid    (date_invalid)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// called at a falling edge, returns at a falling edge;
	// idle cycles first, then hold the transaction until it is taken
	task automatic send_query(date_query_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		first_day       <= q.first_day;
		first_month     <= q.first_month;
		first_year      <= q.first_year;
		second_day      <= q.second_day;
		second_month    <= q.second_month;
		second_year     <= q.second_year;
		include_end_day <= q.include_end_day;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// taken at this edge
		scoreboard.note_query(q);
		@(negedge clk);
	endtask

	function automatic date_query_t make_query(int unsigned d1, int unsigned m1, int unsigned y1,
			int unsigned d2, int unsigned m2, int unsigned y2, int unsigned end_day);
		date_query_t q;
		q.first_day       = DayW'(d1);
		q.first_month     = MonthW'(m1);
		q.first_year      = YearW'(y1);
		q.second_day      = DayW'(d2);
		q.second_month    = MonthW'(m2);
		q.second_year     = YearW'(y2);
		q.include_end_day = 1'(end_day);
		return q;
	endfunction

	// mostly short sweeps, now and then anywhere in the legal range
	function automatic int unsigned pick_year();
		if ($urandom_range(99) < 85)
			return $urandom_range(400, 0);
		return $urandom_range(MaxYearDefault, 0);
	endfunction

	function automatic date_query_t random_query();
		date_query_t q;
		int unsigned roll;
		int unsigned len;
		roll = $urandom_range(99);
		q.include_end_day = 1'($urandom_range(1, 0));
		if (roll < 90) begin
			// well-formed pair, often within one year to get short gaps
			q.first_year   = YearW'(pick_year());
			q.first_month  = MonthW'($urandom_range(12, 1));
			q.first_day    = DayW'($urandom_range(
				scoreboard.days_in(q.first_month, q.first_year), 1));
			q.second_year  = ($urandom_range(99) < 30) ? q.first_year : YearW'(pick_year());
			q.second_month = MonthW'($urandom_range(12, 1));
			q.second_day   = DayW'($urandom_range(
				scoreboard.days_in(q.second_month, q.second_year), 1));
			if (roll >= 80) begin
				// broken: day past month end or zero
				len = scoreboard.days_in(q.second_month, q.second_year);
				if (len < 31 && $urandom_range(1, 0))
					q.second_day = DayW'($urandom_range(31, len + 1));
				else
					q.second_day = 0;
				if ($urandom_range(1, 0)) begin
					q.first_day    = q.second_day;
					q.first_month  = q.second_month;
					q.first_year   = q.second_year;
					q.second_day   = DayW'($urandom_range(28, 1));
				end
			end
		end else begin
			// raw noise on every field, full-width years only half the time
			q.first_day    = DayW'($urandom());
			q.first_month  = MonthW'($urandom());
			q.first_year   = YearW'($urandom_range(1, 0) ? $urandom() : $urandom_range(511, 0));
			q.second_day   = DayW'($urandom());
			q.second_month = MonthW'($urandom());
			q.second_year  = YearW'($urandom_range(1, 0) ? $urandom() : $urandom_range(511, 0));
		end
		return q;
	endfunction

	// receiver: random stall, changed at the falling edge
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// output transactions are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			scoreboard.check_result(day_count, date_invalid);
	end

	// run limit
	initial begin
		while (cycle_count < RunLimitCycles)
			@(posedge clk) cycle_count++;
		$display("[calendar_day_difference] ERROR");
		$finish;
	end

	initial begin
		date_query_t directed[$];

		// equal dates, with and without the end day
		directed.push_back(make_query(1, 1, 2000, 1, 1, 2000, 0));
		directed.push_back(make_query(15, 6, 1987, 15, 6, 1987, 1));
		// february end in common and leap years
		directed.push_back(make_query(28, 2, 2023, 1, 3, 2023, 0));
		directed.push_back(make_query(28, 2, 2024, 1, 3, 2024, 1));
		// leap day in a year divisible by 400
		directed.push_back(make_query(29, 2, 2000, 1, 3, 2000, 0));
		// leap day in a plain century year and in a common year
		directed.push_back(make_query(29, 2, 1900, 1, 1, 1900, 0));
		directed.push_back(make_query(29, 2, 2023, 1, 1, 2023, 0));
		// year zero is a leap year; a year boundary with the end day
		directed.push_back(make_query(29, 2, 0, 1, 1, 1, 0));
		directed.push_back(make_query(31, 12, 1999, 1, 1, 2000, 1));
		// widest spans, both orders
		directed.push_back(make_query(1, 1, 1, 31, 12, 9999, 1));
		directed.push_back(make_query(31, 12, 9999, 1, 1, 0, 0));
		// day past month end, in either date
		directed.push_back(make_query(31, 4, 2021, 1, 5, 2021, 0));
		directed.push_back(make_query(1, 1, 2021, 31, 11, 2021, 0));
		// day zero, month zero, month above twelve
		directed.push_back(make_query(0, 5, 2020, 1, 5, 2020, 0));
		directed.push_back(make_query(10, 0, 2020, 10, 1, 2020, 1));
		directed.push_back(make_query(10, 3, 2020, 10, 13, 2020, 0));
		// every field all ones, year past the top, and the top year itself
		directed.push_back(make_query(31, 15, 16383, 31, 15, 16383, 1));
		directed.push_back(make_query(1, 1, 10000, 1, 1, 9999, 0));
		directed.push_back(make_query(31, 1, 9999, 31, 12, 9999, 0));
		// every field zero, then a plain valid pair
		directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_query(31, 7, 300, 31, 8, 300, 1));

		// hold reset, then release it at a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_query(directed[i]);

		// random part in four idling phases
		for (int unsigned i = 0; i < RandomQueries; i++) begin
			case (i / PhaseLength)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct  = 37;
					recv_stall_pct = 37;
				end
			endcase
			send_query(random_query());
		end
		in_valid <= 1'b0;

		// drain, then watch for stray results
		while (scoreboard.outstanding() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0)
			$display("[calendar_day_difference] OK");
		else
			$display("[calendar_day_difference] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: calendar_day_difference.f
rtl/core/cdd_pkg.sv
rtl/core/cdd_ctrl.sv
rtl/core/cdd_dpath.sv
rtl/core/calendar_day_difference.sv
tb/sv/tb_calendar_day_difference.sv
